// ===== rtl/fpi_pkg.sv =====
`timescale 1ns / 1ps

package fpi_pkg;

   localparam int PIX_FRAC_BITS  = 16;
   localparam int SCALE_FRAC_DEF = 16;

   localparam int RAW_W    = 64;
   localparam int FMT_W    = 3;
   localparam int SCALE_W  = 32;
   localparam int OFFSET_W = 48;
   localparam int PIX_W    = 16;
   localparam int CSR_W    = 48;
   localparam int CSR_IDX_W = 2;

   localparam int F32_MANT_W = 23;
   localparam int F32_EXP_W  = 8;
   localparam int F32_BIAS   = 127;
   localparam int F64_MANT_W = 52;
   localparam int F64_EXP_W  = 11;
   localparam int F64_BIAS   = 1023;

   localparam int MANT_W   = F64_MANT_W + 1;
   localparam int SH_W     = 12;
   localparam int SH_IDX_W = $clog2(RAW_W);
   localparam int MAG_W    = 63;
   localparam int HALF_W   = 32;
   localparam int PROD_W   = MAG_W + SCALE_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int OFF_W    = OFFSET_W + PIX_FRAC_BITS;

   localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_I16 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_F32 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_F64 = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNSIGNED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 2'd3;

   localparam logic [FMT_W-1:0]    FORMAT_RST = FMT_I16;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'd65536;
   localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;

   typedef struct packed {
      logic [FMT_W-1:0]    fmt;
      logic                uns;
      logic [SCALE_W-1:0]  scale_mag;
      logic                scale_neg;
      logic [OFFSET_W-1:0] offset;
   } cfg_type;

   typedef struct packed {
      logic [MANT_W-1:0]      mant;
      logic signed [SH_W-1:0] shift;
      logic                   sat;
      logic                   neg;
   } dec_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
   } mag_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic              neg;
   } prod_type;

endpackage

// ===== rtl/fpi_decode.sv =====
`timescale 1ns / 1ps

module fpi_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  fpi_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [fpi_pkg::RAW_W-1:0]   in_raw,
   output logic                        out_valid,
   input  logic                        out_ready,
   output fpi_pkg::mag_type            out_mag
);

   localparam int WIDE_W = 2 * fpi_pkg::RAW_W;

   logic en_a, en_b;
   logic v_a_ff, v_b_ff;
   fpi_pkg::dec_type dec_in, dec_ff;
   fpi_pkg::mag_type mag_in, mag_ff;

   logic [fpi_pkg::F32_EXP_W-1:0]  f32_exp, f32_ee;
   logic [fpi_pkg::F32_MANT_W-1:0] f32_man;
   logic [fpi_pkg::F64_EXP_W-1:0]  f64_exp, f64_ee;
   logic [fpi_pkg::F64_MANT_W-1:0] f64_man;
   logic signed [fpi_pkg::SH_W-1:0] f32_sh, f64_sh;
   logic [fpi_pkg::MANT_W-1:0]     f32_m, f64_m;
   logic [15:0]                    b16;
   logic [31:0]                    b32;

   logic [WIDE_W-1:0]              wide;
   logic [fpi_pkg::SH_W-1:0]       nsh;

   assign en_b     = !v_b_ff || out_ready;
   assign en_a     = !v_a_ff || en_b;
   assign in_ready = en_a;

   assign f32_exp = in_raw[fpi_pkg::F32_MANT_W +: fpi_pkg::F32_EXP_W];
   assign f32_man = in_raw[fpi_pkg::F32_MANT_W-1:0];
   assign f64_exp = in_raw[fpi_pkg::F64_MANT_W +: fpi_pkg::F64_EXP_W];
   assign f64_man = in_raw[fpi_pkg::F64_MANT_W-1:0];
   assign f32_ee  = (f32_exp == '0) ? fpi_pkg::F32_EXP_W'(1) : f32_exp;
   assign f64_ee  = (f64_exp == '0) ? fpi_pkg::F64_EXP_W'(1) : f64_exp;
   assign f32_sh  = $signed({{(fpi_pkg::SH_W-fpi_pkg::F32_EXP_W){1'b0}}, f32_ee})
                    - fpi_pkg::SH_W'(fpi_pkg::F32_BIAS + fpi_pkg::F32_MANT_W
                                     - fpi_pkg::PIX_FRAC_BITS);
   assign f64_sh  = $signed({{(fpi_pkg::SH_W-fpi_pkg::F64_EXP_W){1'b0}}, f64_ee})
                    - fpi_pkg::SH_W'(fpi_pkg::F64_BIAS + fpi_pkg::F64_MANT_W
                                     - fpi_pkg::PIX_FRAC_BITS);
   assign f32_m   = fpi_pkg::MANT_W'({(f32_exp != '0), f32_man});
   assign f64_m   = {(f64_exp != '0), f64_man};
   assign b16     = in_raw[15:0];
   assign b32     = in_raw[31:0];

   always_comb begin
      dec_in       = '0;
      dec_in.shift = fpi_pkg::SH_W'(fpi_pkg::PIX_FRAC_BITS);
      case (cfg.fmt)
         fpi_pkg::FMT_U8: begin
            dec_in.mant = fpi_pkg::MANT_W'(in_raw[7:0]);
         end
         fpi_pkg::FMT_I16: begin
            if (!cfg.uns && b16[15]) begin
               dec_in.neg  = 1'b1;
               dec_in.mant = fpi_pkg::MANT_W'(16'(~b16 + 16'd1));
            end else begin
               dec_in.mant = fpi_pkg::MANT_W'(b16);
            end
         end
         fpi_pkg::FMT_S32: begin
            if (b32[31]) begin
               dec_in.neg  = 1'b1;
               dec_in.mant = fpi_pkg::MANT_W'(32'(~b32 + 32'd1));
            end else begin
               dec_in.mant = fpi_pkg::MANT_W'(b32);
            end
         end
         fpi_pkg::FMT_F32: begin
            if (f32_exp == '1) begin
               if (f32_man == '0) begin
                  dec_in.sat = 1'b1;
                  dec_in.neg = in_raw[31];
               end
            end else begin
               dec_in.mant  = f32_m;
               dec_in.shift = f32_sh;
               dec_in.neg   = in_raw[31] && (f32_m != '0);
            end
         end
         fpi_pkg::FMT_F64: begin
            if (f64_exp == '1) begin
               if (f64_man == '0) begin
                  dec_in.sat = 1'b1;
                  dec_in.neg = in_raw[fpi_pkg::RAW_W-1];
               end
            end else begin
               dec_in.mant  = f64_m;
               dec_in.shift = f64_sh;
               dec_in.neg   = in_raw[fpi_pkg::RAW_W-1] && (f64_m != '0);
            end
         end
         default: begin
            dec_in.mant = '0;
         end
      endcase
   end

   assign wide = {{(WIDE_W-fpi_pkg::MANT_W){1'b0}}, dec_ff.mant}
                 << dec_ff.shift[fpi_pkg::SH_IDX_W-1:0];
   assign nsh  = fpi_pkg::SH_W'(-dec_ff.shift);

   always_comb begin
      mag_in.neg = dec_ff.neg;
      if (dec_ff.sat) begin
         mag_in.mag = '1;
      end else if (!dec_ff.shift[fpi_pkg::SH_W-1]) begin
         if (($unsigned(dec_ff.shift) >= fpi_pkg::SH_W'(fpi_pkg::MAG_W))
             || (|wide[WIDE_W-1:fpi_pkg::MAG_W])) begin
            mag_in.mag = '1;
         end else begin
            mag_in.mag = wide[fpi_pkg::MAG_W-1:0];
         end
      end else if (nsh >= fpi_pkg::SH_W'(fpi_pkg::RAW_W)) begin
         mag_in.mag = '0;
      end else begin
         mag_in.mag = fpi_pkg::MAG_W'(dec_ff.mant >> nsh[fpi_pkg::SH_IDX_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         if (en_a) begin
            v_a_ff <= in_valid;
         end
         if (en_b) begin
            v_b_ff <= v_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         dec_ff <= dec_in;
      end
      if (en_b) begin
         mag_ff <= mag_in;
      end
   end

   assign out_valid = v_b_ff;
   assign out_mag   = mag_ff;

   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      en_b && v_a_ff && dec_ff.sat |=> mag_ff.mag == '1)
      else $error("saturated float did not give full-scale magnitude");

endmodule

// ===== rtl/fpi_mult.sv =====
`timescale 1ns / 1ps

module fpi_mult (
   input  logic              clock,
   input  logic              reset,
   input  fpi_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpi_pkg::mag_type  in_mag,
   output logic              out_valid,
   input  logic              out_ready,
   output fpi_pkg::prod_type out_prod
);

   localparam int H = fpi_pkg::HALF_W;
   localparam int LO_W = H + fpi_pkg::SCALE_W;
   localparam int HI_W = fpi_pkg::MAG_W - H + fpi_pkg::SCALE_W;

   logic en_c, en_d;
   logic v_c_ff, v_d_ff;
   logic [LO_W-1:0] plo_in, plo_ff;
   logic [HI_W-1:0] phi_in, phi_ff;
   logic            neg_ff;
   fpi_pkg::prod_type prod_in, prod_ff;

   assign en_d     = !v_d_ff || out_ready;
   assign en_c     = !v_c_ff || en_d;
   assign in_ready = en_c;

   assign plo_in = in_mag.mag[H-1:0] * cfg.scale_mag;
   assign phi_in = in_mag.mag[fpi_pkg::MAG_W-1:H] * cfg.scale_mag;

   assign prod_in.prod = fpi_pkg::PROD_W'(plo_ff) + {phi_ff, {H{1'b0}}};
   assign prod_in.neg  = neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
      end else begin
         if (en_c) begin
            v_c_ff <= in_valid;
         end
         if (en_d) begin
            v_d_ff <= v_c_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         neg_ff <= in_mag.neg ^ cfg.scale_neg;
      end
      if (en_d) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = v_d_ff;
   assign out_prod  = prod_ff;

   a_low_half: assert property (@(posedge clock) disable iff (reset)
      en_d && v_c_ff |=> prod_ff.prod[H-1:0] == $past(plo_ff[H-1:0]))
      else $error("low product bits lost in partial-product merge");

endmodule

// ===== rtl/fpi_accum.sv =====
`timescale 1ns / 1ps

module fpi_accum #(
   parameter int SCALE_FRAC_BITS = fpi_pkg::SCALE_FRAC_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fpi_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  fpi_pkg::prod_type         in_prod,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [fpi_pkg::PIX_W-1:0] out_pixel
);

   localparam int SW = fpi_pkg::SUM_W;
   localparam int PW = fpi_pkg::PIX_W;
   localparam int TOT_SHIFT = fpi_pkg::PIX_FRAC_BITS + SCALE_FRAC_BITS;

   logic en_e, en_f;
   logic v_e_ff, v_f_ff;
   logic [SW-1:0] off_ext, prod_ext, sum_in, sum_ff;
   logic [SW-1:0] amag, q;
   logic          rneg;
   logic [PW-1:0] limit, q16, pix_in, pix_ff;

   assign en_f     = !v_f_ff || out_ready;
   assign en_e     = !v_e_ff || en_f;
   assign in_ready = en_e;

   assign off_ext  = {{(SW-fpi_pkg::OFF_W){cfg.offset[fpi_pkg::OFFSET_W-1]}},
                      cfg.offset, {fpi_pkg::PIX_FRAC_BITS{1'b0}}};
   assign prod_ext = {{(SW-fpi_pkg::PROD_W){1'b0}}, in_prod.prod};
   assign sum_in   = in_prod.neg ? (off_ext - prod_ext) : (off_ext + prod_ext);

   assign rneg  = sum_ff[SW-1];
   assign amag  = rneg ? (~sum_ff + SW'(1)) : sum_ff;
   assign q     = amag >> TOT_SHIFT;
   assign limit = rneg ? PW'(32768) : PW'(32767);
   assign q16   = (q > SW'(limit)) ? limit : q[PW-1:0];
   assign pix_in = rneg ? PW'(~q16 + PW'(1)) : q16;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
      end else begin
         if (en_e) begin
            v_e_ff <= in_valid;
         end
         if (en_f) begin
            v_f_ff <= v_e_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         sum_ff <= sum_in;
      end
      if (en_f) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = v_f_ff;
   assign out_pixel = pix_ff;

   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      en_f && v_e_ff && !sum_ff[SW-1] |=> !pix_ff[PW-1])
      else $error("non-negative sum produced a negative pixel");

endmodule

// ===== rtl/fits_pixel_to_int16.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while rsp_stall stays low; six register stages
//   (decode, float align, partial multiply, product merge, offset add, truncate/saturate),
//   each holding one item.
// Reset (synchronous, active high) empties the pipeline and loads the registers with
//   format 16-bit signed, unsigned_sixteen 0, scale 1.0 and offset 0.

module fits_pixel_to_int16 #(
   parameter int SCALE_FRAC_BITS = fpi_pkg::SCALE_FRAC_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fpi_pkg::RAW_W-1:0]       req_raw_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [fpi_pkg::PIX_W-1:0] rsp_pixel_out,
   input  logic                            csr_wr_en,
   input  logic [fpi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpi_pkg::CSR_W-1:0]       csr_wdata
);

   logic [fpi_pkg::FMT_W-1:0]    fmt_ff;
   logic                         uns_ff;
   logic [fpi_pkg::SCALE_W-1:0]  scale_mag_ff;
   logic                         scale_neg_ff;
   logic [fpi_pkg::OFFSET_W-1:0] offset_ff;
   logic [fpi_pkg::SCALE_W-1:0]  scale_w;
   fpi_pkg::cfg_type             cfg;

   logic             dec_ready, dec_valid;
   fpi_pkg::mag_type dec_mag;
   logic             mul_ready, mul_valid;
   fpi_pkg::prod_type mul_prod;
   logic             acc_ready;
   logic [fpi_pkg::PIX_W-1:0] acc_pixel;

   assign scale_w = csr_wdata[fpi_pkg::SCALE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= fpi_pkg::FORMAT_RST;
         uns_ff       <= 1'b0;
         scale_mag_ff <= fpi_pkg::SCALE_RST;
         scale_neg_ff <= 1'b0;
         offset_ff    <= fpi_pkg::OFFSET_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            fpi_pkg::CSR_FORMAT: begin
               fmt_ff <= csr_wdata[fpi_pkg::FMT_W-1:0];
            end
            fpi_pkg::CSR_UNSIGNED: begin
               uns_ff <= csr_wdata[0];
            end
            fpi_pkg::CSR_SCALE: begin
               scale_neg_ff <= scale_w[fpi_pkg::SCALE_W-1];
               scale_mag_ff <= scale_w[fpi_pkg::SCALE_W-1]
                               ? fpi_pkg::SCALE_W'(~scale_w + fpi_pkg::SCALE_W'(1))
                               : scale_w;
            end
            fpi_pkg::CSR_OFFSET: begin
               offset_ff <= csr_wdata[fpi_pkg::OFFSET_W-1:0];
            end
            default: begin
               fmt_ff <= fmt_ff;
            end
         endcase
      end
   end

   assign cfg.fmt       = fmt_ff;
   assign cfg.uns       = uns_ff;
   assign cfg.scale_mag = scale_mag_ff;
   assign cfg.scale_neg = scale_neg_ff;
   assign cfg.offset    = offset_ff;

   fpi_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (dec_ready),
      .in_raw    (req_raw_word),
      .out_valid (dec_valid),
      .out_ready (mul_ready),
      .out_mag   (dec_mag)
   );

   fpi_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (dec_valid),
      .in_ready  (mul_ready),
      .in_mag    (dec_mag),
      .out_valid (mul_valid),
      .out_ready (acc_ready),
      .out_prod  (mul_prod)
   );

   fpi_accum #(
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mul_valid),
      .in_ready  (acc_ready),
      .in_prod   (mul_prod),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_pixel (acc_pixel)
   );

   assign req_stall     = !dec_ready;
   assign rsp_pixel_out = $signed(acc_pixel);

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall)
      else $error("input stalled while the output side is draining");

endmodule

// ===== tb/sv/tb_fits_pixel_to_int16.sv =====
`timescale 1ns / 1ps

module tb_fits_pixel_to_int16;
   import fpi_pkg::*;

   localparam logic [FMT_W-1:0] FMT_NONE    = 3'd5;
   localparam logic [FMT_W-1:0] FMT_SPARE_A = 3'd6;
   localparam logic [FMT_W-1:0] FMT_SPARE_B = 3'd7;
   localparam logic [63:0]      MAG_SAT     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0]      SCALE_ONE   = 32'd65536;

   typedef struct {
      logic [RAW_W-1:0]        raw;
      logic signed [PIX_W-1:0] pixel;
   } pending_pixel_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [RAW_W-1:0]         req_raw_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [PIX_W-1:0]  rsp_pixel_out;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]         csr_wdata = '0;

   logic [FMT_W-1:0]    fmt_q    = FORMAT_RST;
   logic                uns_q    = 1'b0;
   logic [SCALE_W-1:0]  scale_q  = SCALE_RST;
   logic [OFFSET_W-1:0] offset_q = OFFSET_RST;

   pending_pixel_t pending_pixels[$];
   int error_count = 0;
   int burst_left  = 0;
   int gap_max     = 0;
   int stall_pct   = 0;

   fits_pixel_to_int16 uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_word  (req_raw_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] float_to_fixed(input logic [63:0] bits, input int mbits,
                                                  input int ebits, output bit neg);
      logic [63:0] mant, emax, ef, m;
      longint      e, sh, bias;
      mant = bits & ((64'd1 << mbits) - 64'd1);
      emax = (64'd1 << ebits) - 64'd1;
      ef   = (bits >> mbits) & emax;
      bias = longint'(emax >> 1);
      neg  = bits[mbits + ebits];
      if (ef == emax) begin
         if (mant != 0) begin
            neg = 1'b0;
            return 64'd0;
         end
         return MAG_SAT;
      end
      if (ef == 0) begin
         m = mant;
         e = 1 - bias;
      end else begin
         m = mant | (64'd1 << mbits);
         e = longint'(ef) - bias;
      end
      if (m == 0) begin
         neg = 1'b0;
         return 64'd0;
      end
      sh = e - mbits + PIX_FRAC_BITS;
      if (sh >= 0) begin
         if (sh >= 63 || (m >> (63 - sh)) != 0) return MAG_SAT;
         return m << sh;
      end
      if (-sh >= 64) return 64'd0;
      return m >> (-sh);
   endfunction

   function automatic logic signed [PIX_W-1:0] scaled_pixel(input logic [RAW_W-1:0] raw);
      logic [63:0]          mag;
      logic [15:0]          half;
      logic [31:0]          word;
      bit                   pneg;
      logic signed [127:0]  pval, sval, oval, total;
      logic [127:0]         absval, quot;
      logic [15:0]          res;
      mag  = 64'd0;
      pneg = 1'b0;
      case (fmt_q)
         FMT_U8: mag = {56'd0, raw[7:0]};
         FMT_I16: begin
            half = raw[15:0];
            if (!uns_q && half[15]) begin
               pneg = 1'b1;
               half = -half;
            end
            mag = {48'd0, half};
         end
         FMT_S32: begin
            word = raw[31:0];
            if (word[31]) begin
               pneg = 1'b1;
               word = -word;
            end
            mag = {32'd0, word};
         end
         FMT_F32: mag = float_to_fixed({32'd0, raw[31:0]}, F32_MANT_W, F32_EXP_W, pneg);
         FMT_F64: mag = float_to_fixed(raw, F64_MANT_W, F64_EXP_W, pneg);
         default: mag = 64'd0;
      endcase
      if (fmt_q <= FMT_S32) mag = mag << PIX_FRAC_BITS;
      pval = {64'd0, mag};
      if (pneg) pval = -pval;
      sval  = {{96{scale_q[31]}}, scale_q};
      oval  = {{80{offset_q[47]}}, offset_q};
      total = pval * sval + (oval <<< PIX_FRAC_BITS);
      absval = (total < 0) ? -total : total;
      quot   = absval >> (PIX_FRAC_BITS + SCALE_FRAC_DEF);
      if (total < 0) begin
         res = (quot > 128'd32768) ? 16'h8000 : -quot[15:0];
      end else begin
         res = (quot > 128'd32767) ? 16'h7FFF : quot[15:0];
      end
      return $signed(res);
   endfunction

   always @(posedge clock) begin
      pending_pixel_t head;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_pixels.push_back('{req_raw_word, scaled_pixel(req_raw_word)});
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction: expected none, actual pixel_out %0d",
                        $time, rsp_pixel_out);
            end else begin
               head = pending_pixels.pop_front();
               if (rsp_pixel_out !== head.pixel) begin
                  error_count++;
                  $display("%0t: pixel_out for raw %h: expected %0d, actual %0d",
                           $time, head.raw, head.pixel, rsp_pixel_out);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_pixel(input logic [RAW_W-1:0] raw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_raw_word <= raw;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_FORMAT:   fmt_q    = value[FMT_W-1:0];
         CSR_UNSIGNED: uns_q    = value[0];
         CSR_SCALE:    scale_q  = value[SCALE_W-1:0];
         CSR_OFFSET:   offset_q = value[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [FMT_W-1:0] fmt, input logic uns,
                               input logic [SCALE_W-1:0] scale,
                               input logic [OFFSET_W-1:0] offset);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_FORMAT, {junk[47:3], fmt});
      write_reg(CSR_UNSIGNED, {junk[47:1], uns});
      write_reg(CSR_SCALE, {junk[47:32], scale});
      write_reg(CSR_OFFSET, offset);
   endtask

   function automatic logic [RAW_W-1:0] random_raw(input logic [FMT_W-1:0] fmt);
      logic [63:0] r;
      int          pick;
      r    = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 4) return r;
      case (fmt)
         FMT_I16: r[15:0] = 16'($urandom_range(0, 2000)) - 16'd1000;
         FMT_S32: r[31:0] = 32'($urandom_range(0, 200000)) - 32'd100000;
         FMT_F32: begin
            r[30:23] = 8'($urandom_range(100, 150));
            if (pick == 9) begin
               r[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               if ($urandom_range(0, 1)) r[22:0] = '0;
            end
         end
         FMT_F64: begin
            r[62:52] = 11'($urandom_range(1000, 1045));
            if (pick == 9) begin
               r[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
               if ($urandom_range(0, 1)) r[51:0] = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [SCALE_W-1:0] random_scale();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 32'h0004_0000));
         3: return -32'($urandom_range(0, 32'h0004_0000));
         4: return $urandom;
         default: return SCALE_ONE;
      endcase
   endfunction

   function automatic logic [OFFSET_W-1:0] random_offset();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return 48'h8000_0000_0000;
         1: return 48'h7FFF_FFFF_FFFF;
         2: return 48'($urandom_range(0, 32'h07D0_0000));
         3: return -48'($urandom_range(0, 32'h07D0_0000));
         4: return r[47:0];
         default: return '0;
      endcase
   endfunction

   task automatic random_phase(input int count);
      wait_drained();
      apply_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), random_scale(),
                   random_offset());
      gap_max   = $urandom_range(0, 2) * 6;
      stall_pct = $urandom_range(0, 3) * 20;
      repeat (count) send_pixel(random_raw(fmt_q));
   endtask

   task automatic test_sixteen_bit_reset();
      gap_max   = 3;
      stall_pct = 30;
      send_pixel(64'h0);
      send_pixel(64'h7FFF);
      send_pixel(64'h8000);
      send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();
      apply_config(FMT_I16, 1'b1, 32'd32768, '0);
      send_pixel(64'hFFFF);
      send_pixel(64'hA5A5_0000_0000_8001);
   endtask

   task automatic test_integer_formats();
      wait_drained();
      apply_config(FMT_U8, 1'b0, SCALE_ONE, '0);
      send_pixel(64'hFFFF_FFFF_FFFF_FF00);
      send_pixel(64'h0000_0000_0000_00FF);
      wait_drained();
      apply_config(FMT_S32, 1'b0, 32'd1, '0);
      send_pixel(64'h0000_0000_7FFF_FFFF);
      send_pixel(64'hFFFF_FFFF_8000_0000);
   endtask

   task automatic test_float_specials();
      wait_drained();
      apply_config(FMT_F32, 1'b0, SCALE_ONE, '0);
      send_pixel(64'h0000_0000_8000_0000);
      send_pixel(64'h0000_0000_7FC0_0001);
      send_pixel(64'hFFFF_FFFF_FF80_0000);
      send_pixel(64'h0000_0000_0000_0001);
      send_pixel(64'h0000_0000_C030_0000);
      send_pixel(64'h0000_0000_3780_0000);
      wait_drained();
      apply_config(FMT_F64, 1'b0, SCALE_ONE, '0);
      send_pixel(64'h7FF0_0000_0000_0000);
      send_pixel(64'hFFF8_0000_0000_0001);
      send_pixel(64'h8000_0000_0000_0000);
      send_pixel(64'hC0E0_0000_0000_0000);
      send_pixel(64'h3FF8_0000_0000_0000);
   endtask

   task automatic test_unused_formats();
      wait_drained();
      apply_config(FMT_NONE, 1'b0, SCALE_ONE, 48'h0000_04D2_8000);
      send_pixel({$urandom, $urandom});
      wait_drained();
      apply_config(FMT_SPARE_A, 1'b1, 32'h8000_0000, -48'sd475136);
      send_pixel({$urandom, $urandom});
      wait_drained();
      apply_config(FMT_SPARE_B, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
      send_pixel({$urandom, $urandom});
   endtask

   task automatic test_scale_offset_extremes();
      logic [SCALE_W-1:0]  scales[6]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                         SCALE_ONE, -SCALE_ONE, 32'd3};
      logic [OFFSET_W-1:0] offsets[6] = '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h0,
                                          48'hFFFF_FFFF_8000, 48'h0000_7FFF_FFFF, 48'h1};
      logic [FMT_W-1:0]    fmt;
      for (int i = 0; i < 6; i++) begin
         wait_drained();
         fmt = 3'($urandom_range(0, 4));
         apply_config(fmt, 1'(i % 2), scales[i], offsets[5 - i]);
         gap_max   = i * 2;
         stall_pct = (i % 3) * 25;
         repeat (20) send_pixel(random_raw(fmt));
      end
   endtask

   task automatic test_random_configs();
      repeat (12) random_phase(50);
   endtask

   task automatic test_full_rate_backpressure();
      wait_drained();
      apply_config(FMT_F32, 1'b0, 32'd4096, random_offset());
      gap_max   = 0;
      stall_pct = 80;
      repeat (30) send_pixel(random_raw(fmt_q));
      wait_drained();
      repeat (30) send_pixel(random_raw(fmt_q));
      wait_drained();
      stall_pct = 0;
      repeat (60) send_pixel(random_raw(fmt_q));
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_sixteen_bit_reset();
      test_integer_formats();
      test_float_specials();
      test_unused_formats();
      test_scale_offset_extremes();
      test_random_configs();
      test_full_rate_backpressure();
      wait_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fpi_pkg.sv
rtl/fpi_decode.sv
rtl/fpi_mult.sv
rtl/fpi_accum.sv
rtl/fits_pixel_to_int16.sv
tb/sv/tb_fits_pixel_to_int16.sv
